FILE: design/d2r_pkg.sv
package d2r_pkg;

    // Field widths
    localparam int VALUE_W  = 12;
    localparam int SYMBOL_W = 8;
    localparam int STEP_W   = 4;

    // Valid input range
    localparam logic [VALUE_W-1:0] VALUE_MIN = 12'd1;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    // ASCII codes of the numeral characters
    localparam logic [SYMBOL_W-1:0] SYM_NONE = 8'h00;
    localparam logic [SYMBOL_W-1:0] SYM_M    = 8'h4D;
    localparam logic [SYMBOL_W-1:0] SYM_D    = 8'h44;
    localparam logic [SYMBOL_W-1:0] SYM_C    = 8'h43;
    localparam logic [SYMBOL_W-1:0] SYM_L    = 8'h4C;
    localparam logic [SYMBOL_W-1:0] SYM_X    = 8'h58;
    localparam logic [SYMBOL_W-1:0] SYM_V    = 8'h56;
    localparam logic [SYMBOL_W-1:0] SYM_I    = 8'h49;

    // Table steps from M (1000) down to I (1)
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd12;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_PAIR,
        ST_ERR
    } t_state;

    // One result beat
    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                last;
        logic                error;
    } t_beat;

    // Weight of each table step
    function automatic logic [VALUE_W-1:0] f_weight(input logic [STEP_W-1:0] step);
        logic [VALUE_W-1:0] w;
        case (step)
            4'd0:    w = 12'd1000;
            4'd1:    w = 12'd900;
            4'd2:    w = 12'd500;
            4'd3:    w = 12'd400;
            4'd4:    w = 12'd100;
            4'd5:    w = 12'd90;
            4'd6:    w = 12'd50;
            4'd7:    w = 12'd40;
            4'd8:    w = 12'd10;
            4'd9:    w = 12'd9;
            4'd10:   w = 12'd5;
            4'd11:   w = 12'd4;
            4'd12:   w = 12'd1;
            default: w = 12'd1;
        endcase
        return w;
    endfunction

    // First character of each table step
    function automatic logic [SYMBOL_W-1:0] f_sym_first(input logic [STEP_W-1:0] step);
        logic [SYMBOL_W-1:0] s;
        case (step)
            4'd0:    s = SYM_M;
            4'd1:    s = SYM_C;
            4'd2:    s = SYM_D;
            4'd3:    s = SYM_C;
            4'd4:    s = SYM_C;
            4'd5:    s = SYM_X;
            4'd6:    s = SYM_L;
            4'd7:    s = SYM_X;
            4'd8:    s = SYM_X;
            4'd9:    s = SYM_I;
            4'd10:   s = SYM_V;
            4'd11:   s = SYM_I;
            4'd12:   s = SYM_I;
            default: s = SYM_I;
        endcase
        return s;
    endfunction

    // Second character of the subtractive steps
    function automatic logic [SYMBOL_W-1:0] f_sym_second(input logic [STEP_W-1:0] step);
        logic [SYMBOL_W-1:0] s;
        case (step)
            4'd1:    s = SYM_M;
            4'd3:    s = SYM_D;
            4'd5:    s = SYM_C;
            4'd7:    s = SYM_L;
            4'd9:    s = SYM_X;
            4'd11:   s = SYM_V;
            default: s = SYM_I;
        endcase
        return s;
    endfunction

    // Subtractive steps emit two characters
    function automatic logic f_is_pair(input logic [STEP_W-1:0] step);
        logic p;
        case (step)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11: p = 1'b1;
            default:                              p = 1'b0;
        endcase
        return p;
    endfunction

endpackage

FILE: design/d2r_sub_unit.sv
module d2r_sub_unit (
    input  logic [d2r_pkg::VALUE_W-1:0] i_rem,
    input  logic [d2r_pkg::VALUE_W-1:0] i_weight,
    output logic                        o_ge,
    output logic [d2r_pkg::VALUE_W-1:0] o_diff
);
    import d2r_pkg::*;

    // Compare the remainder against the step weight and form the difference
    assign o_ge   = (i_rem >= i_weight);
    assign o_diff = i_rem - i_weight;

endmodule

FILE: design/d2r_seq.sv
module d2r_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [d2r_pkg::VALUE_W-1:0] i_value,
    output logic                        o_ready,
    input  logic                        i_slot_free,
    output logic                        o_emit,
    output d2r_pkg::t_beat              o_beat
);
    import d2r_pkg::*;

    t_state              r_state, n_state;
    logic [VALUE_W-1:0]  r_rem, n_rem;
    logic [STEP_W-1:0]   r_step, n_step;
    logic                w_ge;
    logic [VALUE_W-1:0]  w_diff;
    logic                w_accept;
    logic                w_bad;

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_bad    = (i_value < VALUE_MIN) || (i_value > VALUE_MAX);

    // Shared compare and subtract unit
    d2r_sub_unit u_sub (
        .i_rem    (r_rem),
        .i_weight (f_weight(r_step)),
        .o_ge     (w_ge),
        .o_diff   (w_diff)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = w_bad ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_slot_free && w_ge) begin
                    if (f_is_pair(r_step)) begin
                        n_state = ST_PAIR;
                    end else if (w_diff == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_PAIR: begin
                if (i_slot_free) begin
                    n_state = (r_rem == '0) ? ST_IDLE : ST_RUN;
                end
            end
            ST_ERR: begin
                if (i_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Beat, remainder and step updates
    always_comb begin
        o_emit        = 1'b0;
        o_beat.symbol = SYM_NONE;
        o_beat.last   = 1'b0;
        o_beat.error  = 1'b0;
        n_rem         = r_rem;
        n_step        = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_rem  = i_value;
                    n_step = STEP_FIRST;
                end
            end
            ST_RUN: begin
                if (i_slot_free) begin
                    if (w_ge) begin
                        o_emit        = 1'b1;
                        o_beat.symbol = f_sym_first(r_step);
                        o_beat.last   = !f_is_pair(r_step) && (w_diff == '0);
                        n_rem         = w_diff;
                    end else if (r_step != STEP_LAST) begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            ST_PAIR: begin
                if (i_slot_free) begin
                    o_emit        = 1'b1;
                    o_beat.symbol = f_sym_second(r_step);
                    o_beat.last   = (r_rem == '0);
                end
            end
            ST_ERR: begin
                if (i_slot_free) begin
                    o_emit       = 1'b1;
                    o_beat.last  = 1'b1;
                    o_beat.error = 1'b1;
                end
            end
            default: begin
                o_emit = 1'b0;
            end
        endcase
    end

    // Hold state, remainder and step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_rem  <= n_rem;
        r_step <= n_step;
    end

`ifndef ASSERT_OFF
    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> i_slot_free)
        else $error("beat emitted while output slot occupied");

    a_bad_goes_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_bad) |=> (r_state == ST_ERR))
        else $error("out of range value not flagged");

    a_err_beat_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && o_beat.error) |-> (o_beat.last && (o_beat.symbol == SYM_NONE)))
        else $error("malformed error beat");

    a_good_symbol: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_emit && !o_beat.error) |-> (o_beat.symbol != SYM_NONE))
        else $error("numeral beat without a character");
`endif

endmodule

FILE: design/decimal_to_roman_encoder.sv
// Converts one 12-bit binary number per input beat into its Roman numeral,
// sent as a run of ASCII characters (M D C L X V I), one per output beat,
// with tlast on the final character. Values outside 1 to 3999 give a single
// beat with symbol zero, tuser (error) high and tlast high. The sequencer
// walks a 13-step table from 1000 down to 1 through one shared compare and
// subtract unit: each cycle in which the output slot is free it either emits
// a character or moves to the next step; a full slot holds it. The input side
// is not ready while an item is being converted; the output register lets the
// next item be taken while the last beat of the previous one still waits.
module decimal_to_roman_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [11:0] value, [15:12] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] symbol
    output logic        o_m_tlast,   // last
    output logic        o_m_tuser    // [0] error
);
    import d2r_pkg::*;

    logic  r_out_valid;
    t_beat r_out_beat;
    logic  w_slot_free;
    logic  w_emit;
    t_beat w_beat;

    assign w_slot_free = !r_out_valid || i_m_tready;

    // Conversion sequencer
    d2r_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_value     (i_s_tdata[VALUE_W-1:0]),
        .o_ready     (o_s_tready),
        .i_slot_free (w_slot_free),
        .o_emit      (w_emit),
        .o_beat      (w_beat)
    );

    // Output register: load a new beat or drop the taken one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_out_beat <= w_beat;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_beat.symbol;
    assign o_m_tlast  = r_out_beat.last;
    assign o_m_tuser  = r_out_beat.error;

endmodule
